/* rtl/frp_pkg.sv */
package frp_pkg;

	// field widths
	localparam int FRAC_BITS = 16;
	localparam int NOW_W     = 32;
	localparam int TGT_W     = 10;
	localparam int SKIP_W    = 8;
	localparam int RPT_W     = 16;
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 2;

	// fixed point widths
	localparam int TPF_W  = NOW_W + FRAC_BITS;
	localparam int FPS_W  = 2 * FRAC_BITS + 10;
	localparam int PER_W  = FRAC_BITS + 10;
	localparam int PROD_W = NOW_W + PER_W;
	localparam int SPD_W  = FPS_W + 7;
	localparam int DIV_W  = (SPD_W > TPF_W) ? SPD_W : TPF_W;
	localparam int REM_W  = TPF_W + 1;
	localparam int CNT_W  = $clog2(DIV_W + 1);

	// constants
	localparam int MS_PER_S     = 1000;
	localparam int WIN_MS       = 1000;
	localparam int PCT_FULL     = 100;
	localparam int TGT_RESET    = 25;
	localparam int SKIP_RESET   = 2;

	localparam logic [DIV_W-1:0] K_SEC_FX  = DIV_W'(MS_PER_S) << FRAC_BITS;
	localparam logic [DIV_W-1:0] K_SEC_FX2 = DIV_W'(MS_PER_S) << (2 * FRAC_BITS);
	localparam logic [FPS_W-1:0] FPS_SAT   = FPS_W'({(RPT_W + FRAC_BITS){1'b1}});

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_FPS = 2'd0,
		REG_MAX_SKIP   = 2'd1
	} frp_reg_t;

	// sequencer states
	typedef enum logic [4:0] {
		S_IDLE,
		S_TPF_GO,
		S_TPF_WAIT,
		S_FPS_GO,
		S_FPS_WAIT,
		S_PACE,
		S_PER_GO,
		S_PER_WAIT,
		S_MUL,
		S_CMP,
		S_FPS2_GO,
		S_FPS2_WAIT,
		S_REPORT,
		S_SPD_GO,
		S_SPD_WAIT,
		S_CNT_GO,
		S_CNT_WAIT,
		S_DONE
	} frp_state_t;

	// divider request and response
	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] count;
		logic [DIV_W-1:0] dividend;
		logic [TPF_W-1:0] divisor;
	} frp_div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
	} frp_div_rsp_t;

	// clamp to the report width
	function automatic logic [RPT_W-1:0] sat_rpt(input logic [PROD_W-1:0] v);
		if (v[PROD_W-1:RPT_W] != '0) begin
			return '1;
		end
		return v[RPT_W-1:0];
	endfunction

endpackage

/* rtl/frp_div.sv */
module frp_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  frp_pkg::frp_div_req_t req,
	output frp_pkg::frp_div_rsp_t rsp
);
	import frp_pkg::*;

	logic [DIV_W-1:0] dvd_q;
	logic [REM_W-1:0] rem_q;
	logic [TPF_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	logic [REM_W-1:0] shifted;
	logic [REM_W:0]   trial;
	logic             ge;

	// one restoring step: bring in the next dividend bit, try the subtract
	always_comb begin
		shifted = {rem_q[REM_W-2:0], dvd_q[DIV_W-1]};
		trial   = {1'b0, shifted} - {2'b00, dsr_q};
		ge      = !trial[REM_W];
	end

	// iteration counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (req.start) begin
				cnt_q <= req.count;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// shift registers: quotient bits enter from the bottom as dividend bits leave the top
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
			rem_q <= ge ? trial[REM_W-1:0] : shifted;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dvd_q;

	// a new division only starts on an idle unit
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> cnt_q == '0)
		else $error("divider restarted while busy");

	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(cnt_q) == CNT_W'(1))
		else $error("divider done without final step");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> !done_q || $past(req.start))
		else $error("divider done while still iterating");

endmodule

/* rtl/frame_rate_pacer_core.sv */
// each frame runs up to six divisions in one shared bit-serial divider
// (one quotient bit a cycle) before its result is registered
// flow: one frame at a time; the next frame is taken
// once the result is registered, even while that result still waits to be taken
// reset: asynchronous, active low; target_fps 25, max_skip 2, counters, window and reports 0
module frame_rate_pacer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [frp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [frp_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [frp_pkg::NOW_W-1:0]     now_ms,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [frp_pkg::RPT_W-1:0]     delay_ms,
	output logic                          skip_frame,
	output logic [frp_pkg::NOW_W-1:0]     frame_time_ms,
	output logic                          report_valid,
	output logic [frp_pkg::RPT_W-1:0]     measured_fps,
	output logic [frp_pkg::RPT_W-1:0]     speed_percent,
	output logic [frp_pkg::NOW_W-1:0]     frame_number
);
	import frp_pkg::*;

	frp_state_t state_q, state_nx;

	// configuration and pacing state
	logic [TGT_W-1:0]  target_q;
	logic [SKIP_W-1:0] max_skip_q;
	logic [NOW_W-1:0]  frame_cnt_q;
	logic              started_q;
	logic [NOW_W-1:0]  ws_q;
	logic [NOW_W-1:0]  wf_q;
	logic [NOW_W-1:0]  prev_q;
	logic [SKIP_W-1:0] skip_q;
	logic [RPT_W-1:0]  rfps_q;
	logic [RPT_W-1:0]  rspd_q;

	// per-frame working registers
	logic [NOW_W-1:0]  now_q;
	logic [NOW_W-1:0]  frame_time_q;
	logic [NOW_W-1:0]  elapsed_q;
	logic [TPF_W-1:0]  tpf_q;
	logic [FPS_W-1:0]  fps_q;
	logic [PER_W-1:0]  per_q;
	logic [PROD_W-1:0] prod_q;
	logic [RPT_W-1:0]  delay_q;
	logic              report_q;

	// result register
	logic              out_valid_q;
	logic [RPT_W-1:0]  out_delay_q;
	logic              out_skip_q;
	logic [NOW_W-1:0]  out_ftime_q;
	logic              out_report_q;
	logic [RPT_W-1:0]  out_fps_q;
	logic [RPT_W-1:0]  out_speed_q;
	logic [NOW_W-1:0]  out_fnum_q;

	frp_div_req_t div_req;
	frp_div_rsp_t div_rsp;

	logic                   in_fire;
	logic                   out_free;
	logic [NOW_W-1:0]       tpi;
	logic                   tpi_zero;
	logic                   tpf_zero;
	logic [TPF_W-1:0]       el_fx;
	logic                   ahead;
	logic [PROD_W-1:0]      prod_full;
	logic [PROD_W-1:0]      diff;
	logic                   pace_wait;
	logic [SPD_W-1:0]       fps100;
	logic                   report_due;
	logic [NOW_W-1:0]       rest;
	logic [NOW_W-1:0]       cnt_next;

	frp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// derived values
	always_comb begin
		in_fire    = in_valid && in_ready;
		out_free   = !out_valid_q || out_ready;
		tpi        = tpf_q[TPF_W-1:FRAC_BITS];
		tpi_zero   = (tpi == '0);
		tpf_zero   = (tpf_q == '0);
		el_fx      = {elapsed_q, {FRAC_BITS{1'b0}}};
		ahead      = fps_q[FPS_W-1:FRAC_BITS] > (FPS_W - FRAC_BITS)'(target_q);
		diff       = prod_q - PROD_W'(el_fx);
		pace_wait  = (prod_q > PROD_W'(el_fx)) && (diff[PROD_W-1:FRAC_BITS] != '0);
		fps100     = (SPD_W'(fps_q) << 6) + (SPD_W'(fps_q) << 5) + (SPD_W'(fps_q) << 2);
		report_due = elapsed_q >= NOW_W'(WIN_MS);
		rest       = elapsed_q - NOW_W'(WIN_MS);
		cnt_next   = (div_rsp.quot[NOW_W-1:0] == '1) ? '1
		             : div_rsp.quot[NOW_W-1:0] + NOW_W'(1);
	end

	// frames in a window times the target period
	assign prod_full = wf_q * per_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// sequencer: next state, divider requests, input ready
	always_comb begin
		state_nx = state_q;
		div_req  = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_nx = S_TPF_GO;
				end
			end
			S_TPF_GO: begin
				div_req.start    = 1'b1;
				div_req.count    = CNT_W'(TPF_W);
				div_req.dividend = DIV_W'(el_fx) << (DIV_W - TPF_W);
				div_req.divisor  = TPF_W'(wf_q);
				state_nx         = S_TPF_WAIT;
			end
			S_TPF_WAIT: begin
				if (div_rsp.done) begin
					state_nx = S_FPS_GO;
				end
			end
			S_FPS_GO: begin
				if (tpi_zero) begin
					state_nx = S_PACE;
				end else begin
					div_req.start    = 1'b1;
					div_req.count    = CNT_W'(PER_W);
					div_req.dividend = K_SEC_FX << (DIV_W - PER_W);
					div_req.divisor  = TPF_W'(tpi);
					state_nx         = S_FPS_WAIT;
				end
			end
			S_FPS_WAIT: begin
				if (div_rsp.done) begin
					state_nx = S_PACE;
				end
			end
			S_PACE: begin
				if (target_q != '0 && ahead) begin
					state_nx = S_PER_GO;
				end else begin
					state_nx = S_REPORT;
				end
			end
			S_PER_GO: begin
				div_req.start    = 1'b1;
				div_req.count    = CNT_W'(PER_W);
				div_req.dividend = K_SEC_FX << (DIV_W - PER_W);
				div_req.divisor  = TPF_W'(target_q);
				state_nx         = S_PER_WAIT;
			end
			S_PER_WAIT: begin
				if (div_rsp.done) begin
					state_nx = S_MUL;
				end
			end
			S_MUL: begin
				state_nx = S_CMP;
			end
			S_CMP: begin
				if (pace_wait && !tpf_zero) begin
					state_nx = S_FPS2_GO;
				end else begin
					state_nx = S_REPORT;
				end
			end
			S_FPS2_GO: begin
				div_req.start    = 1'b1;
				div_req.count    = CNT_W'(FPS_W);
				div_req.dividend = K_SEC_FX2 << (DIV_W - FPS_W);
				div_req.divisor  = tpf_q;
				state_nx         = S_FPS2_WAIT;
			end
			S_FPS2_WAIT: begin
				if (div_rsp.done) begin
					state_nx = S_REPORT;
				end
			end
			S_REPORT: begin
				if (report_due && target_q != '0) begin
					state_nx = S_SPD_GO;
				end else begin
					state_nx = S_DONE;
				end
			end
			S_SPD_GO: begin
				div_req.start    = 1'b1;
				div_req.count    = CNT_W'(SPD_W);
				div_req.dividend = DIV_W'(fps100) << (DIV_W - SPD_W);
				div_req.divisor  = TPF_W'(target_q);
				state_nx         = S_SPD_WAIT;
			end
			S_SPD_WAIT: begin
				if (div_rsp.done) begin
					state_nx = S_CNT_GO;
				end
			end
			S_CNT_GO: begin
				div_req.start    = 1'b1;
				div_req.count    = CNT_W'(NOW_W);
				div_req.dividend = DIV_W'(rest) << (DIV_W - NOW_W);
				div_req.divisor  = TPF_W'(tpi);
				state_nx         = S_CNT_WAIT;
			end
			S_CNT_WAIT: begin
				if (div_rsp.done) begin
					state_nx = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// configuration, window, skip counter, reports and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= TGT_W'(TGT_RESET);
			max_skip_q  <= SKIP_W'(SKIP_RESET);
			frame_cnt_q <= '0;
			started_q   <= 1'b0;
			ws_q        <= '0;
			wf_q        <= '0;
			prev_q      <= '0;
			skip_q      <= '0;
			rfps_q      <= '0;
			rspd_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// register writes restart the window
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_TARGET_FPS: begin
						target_q  <= cfg_wdata[TGT_W-1:0];
						started_q <= 1'b0;
						wf_q      <= '0;
					end
					REG_MAX_SKIP: begin
						max_skip_q <= cfg_wdata[SKIP_W-1:0];
						started_q  <= 1'b0;
						wf_q       <= '0;
					end
					default: begin
					end
				endcase
			end

			// new frame beat
			if (in_fire) begin
				frame_cnt_q <= frame_cnt_q + NOW_W'(1);
				prev_q      <= now_ms;
				if (!started_q) begin
					ws_q      <= now_ms;
					wf_q      <= NOW_W'(1);
					started_q <= 1'b1;
				end else begin
					wf_q <= wf_q + NOW_W'(1);
				end
			end

			// skip counter
			if (state_q == S_PACE) begin
				if (target_q == '0 || ahead) begin
					skip_q <= '0;
				end else if (skip_q < max_skip_q) begin
					skip_q <= skip_q + SKIP_W'(1);
				end else begin
					skip_q <= '0;
				end
			end

			// one-second report
			if (state_q == S_REPORT && report_due) begin
				if (target_q == '0) begin
					rspd_q <= RPT_W'(PCT_FULL);
					rfps_q <= sat_rpt(PROD_W'(wf_q));
					wf_q   <= '0;
					ws_q   <= now_q;
				end else begin
					rfps_q <= sat_rpt(PROD_W'(fps_q[FPS_W-1:FRAC_BITS]));
				end
			end
			if (state_q == S_SPD_WAIT && div_rsp.done) begin
				rspd_q <= sat_rpt(PROD_W'(div_rsp.quot[DIV_W-1:FRAC_BITS]));
			end

			// window moves forward, keeping the frames that fit in the rest
			if (state_q == S_CNT_WAIT && div_rsp.done) begin
				wf_q <= cnt_next;
				ws_q <= ws_q + NOW_W'(WIN_MS);
			end

			// result beat handshake
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// per-frame working values and the result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			now_q        <= now_ms;
			frame_time_q <= now_ms - prev_q;
			elapsed_q    <= started_q ? now_ms - ws_q : '0;
			delay_q      <= '0;
			report_q     <= 1'b0;
		end

		if (state_q == S_TPF_WAIT && div_rsp.done) begin
			tpf_q <= div_rsp.quot[TPF_W-1:0];
		end

		// measured rate from the integer period
		if (state_q == S_FPS_GO && tpi_zero) begin
			fps_q <= FPS_SAT;
		end
		if (state_q == S_FPS_WAIT && div_rsp.done) begin
			fps_q <= FPS_W'(div_rsp.quot[PER_W-1:0]);
		end

		if (state_q == S_PER_WAIT && div_rsp.done) begin
			per_q <= div_rsp.quot[PER_W-1:0];
		end

		if (state_q == S_MUL) begin
			prod_q <= prod_full;
		end

		// wait needed to fall back to the target period
		if (state_q == S_CMP && pace_wait) begin
			delay_q <= sat_rpt(PROD_W'(diff[PROD_W-1:FRAC_BITS]));
			if (tpf_zero) begin
				fps_q <= FPS_SAT;
			end
		end
		if (state_q == S_FPS2_WAIT && div_rsp.done) begin
			fps_q <= div_rsp.quot[FPS_W-1:0];
		end

		if (state_q == S_REPORT) begin
			report_q <= report_due;
		end

		if (state_q == S_DONE && out_free) begin
			out_delay_q  <= delay_q;
			out_skip_q   <= (skip_q != '0);
			out_ftime_q  <= frame_time_q;
			out_report_q <= report_q;
			out_fps_q    <= rfps_q;
			out_speed_q  <= rspd_q;
			out_fnum_q   <= frame_cnt_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign delay_ms      = out_delay_q;
	assign skip_frame    = out_skip_q;
	assign frame_time_ms = out_ftime_q;
	assign report_valid  = out_report_q;
	assign measured_fps  = out_fps_q;
	assign speed_percent = out_speed_q;
	assign frame_number  = out_fnum_q;

	// one frame in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("second frame taken while one is in progress");

	a_frame_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> frame_cnt_q == $past(frame_cnt_q) + NOW_W'(1))
		else $error("frame counter did not advance by one");

	a_wait_or_skip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(delay_ms != '0 && skip_frame))
		else $error("frame both delayed and skipped");

	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_TPF_WAIT || state_q == S_FPS_WAIT ||
		                  state_q == S_PER_WAIT || state_q == S_FPS2_WAIT ||
		                  state_q == S_SPD_WAIT || state_q == S_CNT_WAIT))
		else $error("division finished outside a wait state");

endmodule

/* tb/sv/tb_frame_rate_pacer_core.sv */
module tb_frame_rate_pacer_core;
	import frp_pkg::*;

	localparam int LIMIT       = 50_000_000;
	localparam int HOLD_CYCLES = 1000;
	localparam int DRAIN_WAIT  = 300;

	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam logic [63:0] FRAC_ONES = (64'd1 << FRAC_BITS) - 64'd1;
	localparam logic [63:0] FPS_FULL  = (64'(16'hFFFF) << FRAC_BITS) | FRAC_ONES;
	localparam logic [63:0] TPF_FULL  = (64'(32'hFFFF_FFFF) << FRAC_BITS) | FRAC_ONES;

	typedef struct packed {
		logic [RPT_W-1:0] delay;
		logic             skip;
		logic [NOW_W-1:0] ftime;
		logic             report;
		logic [RPT_W-1:0] fps;
		logic [RPT_W-1:0] speed;
		logic [NOW_W-1:0] fnum;
	} pacer_result_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [NOW_W-1:0]     now_ms = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [RPT_W-1:0]     delay_ms;
	logic                 skip_frame;
	logic [NOW_W-1:0]     frame_time_ms;
	logic                 report_valid;
	logic [RPT_W-1:0]     measured_fps;
	logic [RPT_W-1:0]     speed_percent;
	logic [NOW_W-1:0]     frame_number;

	// stimulus and scoreboard
	logic [NOW_W-1:0] stamp_q[$];
	pacer_result_t    paced_q[$];
	pacer_result_t    want;
	logic [NOW_W-1:0] clock_ms;
	int               send_idle_pct;
	int               stall_pct;
	logic             long_hold;
	int               hold_cnt = 0;
	int               mismatches = 0;

	// predictor state and registers
	logic [TGT_W-1:0]  pace_target;
	logic [SKIP_W-1:0] pace_skip_lim;
	logic [NOW_W-1:0]  frames_seen;
	logic              win_open;
	logic [NOW_W-1:0]  win_start;
	logic [NOW_W-1:0]  win_frames;
	logic [NOW_W-1:0]  last_ms;
	logic [SKIP_W-1:0] skip_run;
	logic [RPT_W-1:0]  shown_fps;
	logic [RPT_W-1:0]  shown_speed;

	frame_rate_pacer_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.now_ms        (now_ms),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.delay_ms      (delay_ms),
		.skip_frame    (skip_frame),
		.frame_time_ms (frame_time_ms),
		.report_valid  (report_valid),
		.measured_fps  (measured_fps),
		.speed_percent (speed_percent),
		.frame_number  (frame_number)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(LIMIT);
		$display("frame_rate_pacer_core regression: fail");
		$finish;
	end

	function automatic logic [RPT_W-1:0] clamp16(input logic [63:0] v);
		return (v > 64'hFFFF) ? 16'hFFFF : v[RPT_W-1:0];
	endfunction

	// advance the pacing state by one frame start and form its result
	function automatic pacer_result_t pace_frame(input logic [NOW_W-1:0] stamp);
		logic [NOW_W-1:0] elapsed, tpi, rest;
		logic [63:0]      el_fx, tpf, fps, per, prod, d, q;
		pacer_result_t    r;
		r = '0;
		frames_seen = frames_seen + 1;
		if (!win_open) begin
			win_frames = '0;
			win_start  = stamp;
			win_open   = 1'b1;
		end
		r.ftime    = stamp - last_ms;
		win_frames = win_frames + 1;

		// mean period and rate over the window
		elapsed = stamp - win_start;
		el_fx   = 64'(elapsed) << FRAC_BITS;
		if (win_frames == '0) begin
			tpf = TPF_FULL;
		end else begin
			tpf = el_fx / win_frames;
		end
		tpi = 32'(tpf >> FRAC_BITS);
		fps = (tpi == '0) ? FPS_FULL : (64'(MS_PER_S) << FRAC_BITS) / tpi;

		// ahead of target: wait; behind: skip run
		if (pace_target != '0) begin
			if ((fps >> FRAC_BITS) > pace_target) begin
				per  = (64'(MS_PER_S) << FRAC_BITS) / pace_target;
				prod = 64'(win_frames) * per;
				if (prod > el_fx) begin
					d = (prod - el_fx) >> FRAC_BITS;
					if (d != 0) begin
						r.delay = clamp16(d);
						fps = (tpf == 0) ? FPS_FULL
							: (64'(MS_PER_S) << (2 * FRAC_BITS)) / tpf;
					end
				end
				skip_run = '0;
			end else if (skip_run < pace_skip_lim) begin
				skip_run = skip_run + SKIP_W'(1);
			end else begin
				skip_run = '0;
			end
		end else begin
			skip_run = '0;
		end

		// once-a-second report and window slide
		if (elapsed >= WIN_MS) begin
			rest     = elapsed - WIN_MS;
			r.report = 1'b1;
			if (pace_target != '0) begin
				shown_speed = clamp16(((fps * PCT_FULL) / pace_target) >> FRAC_BITS);
				shown_fps   = clamp16(fps >> FRAC_BITS);
				q = (tpi == '0) ? 64'hFFFF_FFFF : 64'(rest / tpi);
				q = q + 1;
				win_frames = (q > 64'hFFFF_FFFF) ? '1 : q[NOW_W-1:0];
				win_start  = stamp - rest;
			end else begin
				shown_speed = RPT_W'(PCT_FULL);
				shown_fps   = clamp16(64'(win_frames));
				win_frames  = '0;
				win_start   = stamp;
			end
		end

		last_ms = stamp;
		r.skip  = (skip_run != '0);
		r.fps   = shown_fps;
		r.speed = shown_speed;
		r.fnum  = frames_seen;
		return r;
	endfunction

	// driver: offers stamps, predicts each accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			now_ms   <= '0;
		end else begin
			if (in_valid && in_ready) begin
				paced_q.push_back(pace_frame(now_ms));
			end
			if (!in_valid || in_ready) begin
				if (stamp_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					now_ms   <= stamp_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	// monitor: takes result beats, long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (paced_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result beat, expected none actual frame %0d",
						$time, frame_number);
				end else begin
					want = paced_q.pop_front();
					check_field("delay_ms", want.delay, delay_ms);
					check_field("skip_frame", want.skip, skip_frame);
					check_field("frame_time_ms", want.ftime, frame_time_ms);
					check_field("report_valid", want.report, report_valid);
					check_field("measured_fps", want.fps, measured_fps);
					check_field("speed_percent", want.speed, speed_percent);
					check_field("frame_number", want.fnum, frame_number);
				end
			end
			if (long_hold && hold_cnt < HOLD_CYCLES) begin
				out_ready <= 1'b0;
				hold_cnt  <= hold_cnt + 1;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic wait_idle();
		do @(negedge clk);
		while (stamp_q.size() != 0 || in_valid || paced_q.size() != 0);
	endtask

	// register write, mirrored into the predictor
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_TARGET_FPS: begin
				pace_target = data[TGT_W-1:0];
				win_open    = 1'b0;
				win_frames  = '0;
			end
			REG_MAX_SKIP: begin
				pace_skip_lim = data[SKIP_W-1:0];
				win_open      = 1'b0;
				win_frames    = '0;
			end
			default: begin
			end
		endcase
		@(negedge clk);
	endtask

	task automatic push_stamp(input logic [NOW_W-1:0] t);
		clock_ms = t;
		stamp_q.push_back(t);
	endtask

	// one stretch of frames at a random setting, mostly near the target period
	task automatic run_segment(input int n);
		int               kind, base, jit, step, r;
		logic [CFG_W-1:0] tval, sval;
		kind = $urandom_range(7);
		case (kind)
			0:       tval = '0;
			1:       tval = 10'd1;
			2:       tval = 10'd1000;
			3:       tval = 10'h3FF;
			4:       tval = 10'd25;
			5:       tval = 10'd60;
			default: tval = CFG_W'($urandom_range(1, 200));
		endcase
		case ($urandom_range(4))
			0:       sval = {2'($urandom_range(3)), 8'd0};
			1:       sval = {2'($urandom_range(3)), 8'd1};
			2:       sval = {2'($urandom_range(3)), 8'hFF};
			default: sval = CFG_W'($urandom_range(1023));
		endcase
		wait_idle();
		if ($urandom_range(1)) begin
			write_reg(REG_TARGET_FPS, tval);
			write_reg(REG_MAX_SKIP, sval);
		end else begin
			write_reg(REG_MAX_SKIP, sval);
			write_reg(REG_TARGET_FPS, tval);
		end
		if ($urandom_range(3) == 0) begin
			write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
				CFG_W'($urandom_range(1023)));
		end
		if ($urandom_range(3) == 0) begin
			clock_ms = $urandom();
		end
		if (tval == '0) begin
			base = $urandom_range(5, 120);
		end else if (tval >= MS_PER_S) begin
			base = 1;
		end else begin
			base = MS_PER_S / int'(tval);
		end
		jit = base / 4 + 1;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 70) begin
				step = base - jit + $urandom_range(2 * jit);
			end else if (r < 80) begin
				step = 0;
			end else if (r < 88) begin
				step = $urandom_range(1, 3 * base + 2);
			end else if (r < 94) begin
				step = $urandom_range(1000, 5000);
			end else if (r < 97) begin
				clock_ms = $urandom();
				step = 0;
			end else begin
				step = -$urandom_range(1, 200);
			end
			push_stamp(clock_ms + 32'(step));
		end
	endtask

	initial begin
		int idle_tab[4], stall_tab[4];
		cfg_wr_en = 1'b0;
		cfg_index = REG_TARGET_FPS;
		cfg_wdata = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		long_hold = 1'b0;
		clock_ms = '0;
		pace_target = TGT_RESET;
		pace_skip_lim = SKIP_RESET;
		frames_seen = '0;
		win_open = 1'b0;
		win_start = '0;
		win_frames = '0;
		last_ms = '0;
		skip_run = '0;
		shown_fps = '0;
		shown_speed = '0;
		idle_tab  = '{0, 68, 0, 26};
		stall_tab = '{0, 0, 68, 26};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: repeated stamp, report, backwards and wrapping time
		push_stamp(32'd0);
		push_stamp(32'd0);
		push_stamp(32'd40);
		push_stamp(32'd80);
		push_stamp(32'd120);
		push_stamp(32'd1000);
		push_stamp(32'd1040);
		push_stamp(32'hFFFF_FFF0);
		push_stamp(32'hFFFF_FFFF);
		push_stamp(32'h0000_0005);
		push_stamp(32'h8000_0000);
		wait_idle();

		// pacing off, report counts frames
		write_reg(REG_TARGET_FPS, 10'd0);
		write_reg(REG_MAX_SKIP, 10'd1);
		push_stamp(32'd100);
		push_stamp(32'd150);
		push_stamp(32'd1200);
		push_stamp(32'd1250);
		wait_idle();

		// target of 1000 fps, no skipping allowed
		write_reg(REG_TARGET_FPS, 10'd1000);
		write_reg(REG_MAX_SKIP, 10'd0);
		push_stamp(32'd10);
		push_stamp(32'd11);
		push_stamp(32'd11);
		push_stamp(32'd12);
		wait_idle();

		// lowest target, upper data bits dropped by the skip limit
		write_reg(REG_TARGET_FPS, 10'd1);
		write_reg(REG_MAX_SKIP, 10'h3FF);
		push_stamp(32'd0);
		push_stamp(32'd3000);
		push_stamp(32'd6000);
		push_stamp(32'd6001);

		// random stretches under each idling mode
		for (int m = 0; m < 4; m++) begin
			wait_idle();
			send_idle_pct = idle_tab[m];
			stall_pct = stall_tab[m];
			for (int s = 0; s < 5; s++) begin
				run_segment(14 + $urandom_range(6));
				if (m == 0 && s == 1) begin
					long_hold = 1'b1;
				end
			end
		end

		// long skip run that wraps past the widest limit
		wait_idle();
		send_idle_pct = 0;
		stall_pct = 0;
		write_reg(REG_TARGET_FPS, 10'd1000);
		write_reg(REG_MAX_SKIP, 10'd255);
		clock_ms = $urandom();
		for (int i = 0; i < 270; i++) begin
			push_stamp(clock_ms + 32'($urandom_range(1, 4)));
		end

		wait_idle();
		repeat (DRAIN_WAIT) @(negedge clk);
		if (mismatches == 0 && paced_q.size() == 0) begin
			$display("frame_rate_pacer_core regression: pass");
		end else begin
			$display("frame_rate_pacer_core regression: fail");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/frp_pkg.sv
rtl/frp_div.sv
rtl/frame_rate_pacer_core.sv
tb/sv/tb_frame_rate_pacer_core.sv
